>>> rtl/core/alsag_pkg.sv
// shared types and constants for the load/store address generator
package alsag_pkg;

  typedef enum logic [1:0] {
    OP_M2_IMM = 2'd0,
    OP_M2_REG = 2'd1,
    OP_M3_IMM = 2'd2,
    OP_M3_REG = 2'd3
  } alsag_op_t;

  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } alsag_shift_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_OFFSET = 2'd1,
    KIND_PRE    = 2'd2,
    KIND_POST   = 2'd3
  } alsag_kind_t;

  localparam logic [7:0] MODE3_IMM_MASK = 8'hFF;

  typedef struct packed {
    logic mode3;
    logic pre;
    logic up;
    logic wb;
    logic cin;
  } alsag_ctrl_t;

endpackage

>>> rtl/core/alsag_shift.sv
// first stage: offset selection and index barrel shift
module alsag_shift (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [1:0]            opcode,
  input  logic [31:0]           base_value,
  input  logic [31:0]           index_value,
  input  logic [11:0]           imm_offset,
  input  logic                  pre_index,
  input  logic                  add_offset,
  input  logic                  writeback_bit,
  input  logic [4:0]            shift_amount,
  input  logic [1:0]            shift_type,
  input  logic                  carry_in,
  output logic                  valid,
  output alsag_pkg::alsag_ctrl_t ctrl,
  output logic [31:0]           base,
  output logic [31:0]           offset,
  output logic                  carry
);
  import alsag_pkg::*;

  logic [32:0] lsl_w;
  logic [32:0] lsr_w;
  logic [32:0] asr_w;
  logic [31:0] ror_w;
  logic [31:0] shifted;
  logic        shift_c;
  logic [31:0] offset_next;
  logic        carry_next;

  always_comb begin
    lsl_w = {1'b0, index_value} << shift_amount;
    lsr_w = {index_value, 1'b0} >> shift_amount;
    asr_w = 33'($signed({index_value, 1'b0}) >>> shift_amount);
    ror_w = 32'({index_value, index_value} >> shift_amount);
    shifted = index_value;
    shift_c = carry_in;
    case (alsag_shift_t'(shift_type))
      SHIFT_LSL: begin
        if (shift_amount != 5'd0) begin
          shifted = lsl_w[31:0];
          shift_c = lsl_w[32];
        end
      end
      SHIFT_LSR: begin
        if (shift_amount == 5'd0) begin
          shifted = 32'd0;
          shift_c = index_value[31];
        end else begin
          shifted = lsr_w[32:1];
          shift_c = lsr_w[0];
        end
      end
      SHIFT_ASR: begin
        if (shift_amount == 5'd0) begin
          shifted = {32{index_value[31]}};
          shift_c = index_value[31];
        end else begin
          shifted = asr_w[32:1];
          shift_c = asr_w[0];
        end
      end
      SHIFT_ROR: begin
        if (shift_amount == 5'd0) begin
          shifted = {carry_in, index_value[31:1]};
          shift_c = index_value[0];
        end else begin
          shifted = ror_w;
          shift_c = ror_w[31];
        end
      end
      default: begin
        shifted = index_value;
        shift_c = carry_in;
      end
    endcase
  end

  always_comb begin
    offset_next = index_value;
    carry_next  = carry_in;
    case (alsag_op_t'(opcode))
      OP_M2_IMM: offset_next = {20'd0, imm_offset};
      OP_M2_REG: begin
        offset_next = shifted;
        carry_next  = shift_c;
      end
      OP_M3_IMM: offset_next = {24'd0, imm_offset[7:0] & MODE3_IMM_MASK};
      OP_M3_REG: offset_next = index_value;
      default:   offset_next = index_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl.mode3 <= opcode[1];
      ctrl.pre   <= pre_index;
      ctrl.up    <= add_offset;
      ctrl.wb    <= writeback_bit;
      ctrl.cin   <= carry_in;
      base       <= base_value;
      offset     <= offset_next;
      carry      <= carry_next;
    end
  end

endmodule

>>> rtl/core/alsag_sum.sv
// second stage: base plus or minus offset
module alsag_sum (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  alsag_pkg::alsag_ctrl_t in_ctrl,
  input  logic [31:0]            in_base,
  input  logic [31:0]            in_offset,
  input  logic                   in_carry,
  output logic                   valid,
  output alsag_pkg::alsag_ctrl_t ctrl,
  output logic [31:0]            base,
  output logic [31:0]            moved,
  output logic                   carry
);
  import alsag_pkg::*;

  logic [31:0] moved_next;

  assign moved_next = in_ctrl.up ? in_base + in_offset : in_base - in_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl  <= in_ctrl;
      base  <= in_base;
      moved <= moved_next;
      carry <= in_carry;
    end
  end

endmodule

>>> rtl/core/alsag_form.sv
// third stage: access kind, address and writeback forming, output register
module alsag_form (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  alsag_pkg::alsag_ctrl_t in_ctrl,
  input  logic [31:0]            in_base,
  input  logic [31:0]            in_moved,
  input  logic                   in_carry,
  output logic                   valid,
  output logic [1:0]             access_kind,
  output logic [31:0]            access_address,
  output logic [31:0]            new_base,
  output logic                   base_write_enable,
  output logic                   shifter_carry_out,
  output logic                   user_mode_access
);
  import alsag_pkg::*;

  alsag_kind_t kind_next;
  logic [31:0] addr_next;
  logic [31:0] nb_next;
  logic        we_next;
  logic        carry_next;
  logic        user_next;

  always_comb begin
    addr_next  = in_moved;
    nb_next    = in_base;
    we_next    = 1'b0;
    carry_next = in_carry;
    user_next  = 1'b0;
    kind_next  = KIND_OFFSET;
    if (in_ctrl.pre) begin
      if (in_ctrl.wb) begin
        kind_next = KIND_PRE;
        nb_next   = in_moved;
        we_next   = 1'b1;
      end
    end else if (!in_ctrl.wb || !in_ctrl.mode3) begin
      kind_next = KIND_POST;
      addr_next = in_base;
      nb_next   = in_moved;
      we_next   = 1'b1;
      user_next = in_ctrl.wb;
    end else begin
      // halfword post-indexed with writeback: no access
      kind_next  = KIND_NONE;
      addr_next  = 32'd0;
      carry_next = in_ctrl.cin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      access_kind       <= kind_next;
      access_address    <= addr_next;
      new_base          <= nb_next;
      base_write_enable <= we_next;
      shifter_carry_out <= carry_next;
      user_mode_access  <= user_next;
    end
  end

endmodule

>>> rtl/core/arm_load_store_address_gen_top.sv
// top level of the load/store address generator
//
// input channel: in_valid / in_stall carry one decoded load/store word
// (opcode, base and index values, immediate, p/u/w bits, shift, carry).
// output channel: out_valid / out_stall carry one result word (access kind,
// address, new base, writeback enable, shifter carry, user-mode flag).
// every input word gives exactly one result word.
// the stages are index shift, add/subtract and result forming,
// each ending in a register; the last one is the output register.
// throughput is one word per cycle while the output is not stalled.
// when out_stall is high with a result waiting, the whole pipeline holds
// and in_stall goes high in the same cycle; nothing is dropped or repeated.
// synchronous reset clears the valid bits of all three stages; data
// registers are not reset.
module arm_load_store_address_gen_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] base_value,
  input  logic [31:0] index_value,
  input  logic [11:0] imm_offset,
  input  logic        pre_index,
  input  logic        add_offset,
  input  logic        writeback_bit,
  input  logic [4:0]  shift_amount,
  input  logic [1:0]  shift_type,
  input  logic        carry_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  access_kind,
  output logic [31:0] access_address,
  output logic [31:0] new_base,
  output logic        base_write_enable,
  output logic        shifter_carry_out,
  output logic        user_mode_access
);
  import alsag_pkg::*;

  logic        adv;
  logic        s1_valid;
  alsag_ctrl_t s1_ctrl;
  logic [31:0] s1_base;
  logic [31:0] s1_offset;
  logic        s1_carry;
  logic        s2_valid;
  alsag_ctrl_t s2_ctrl;
  logic [31:0] s2_base;
  logic [31:0] s2_moved;
  logic        s2_carry;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  alsag_shift u_shift (
    .clk           (clk),
    .rst           (rst),
    .en            (adv),
    .in_valid      (in_valid),
    .opcode        (opcode),
    .base_value    (base_value),
    .index_value   (index_value),
    .imm_offset    (imm_offset),
    .pre_index     (pre_index),
    .add_offset    (add_offset),
    .writeback_bit (writeback_bit),
    .shift_amount  (shift_amount),
    .shift_type    (shift_type),
    .carry_in      (carry_in),
    .valid         (s1_valid),
    .ctrl          (s1_ctrl),
    .base          (s1_base),
    .offset        (s1_offset),
    .carry         (s1_carry)
  );

  alsag_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s1_valid),
    .in_ctrl   (s1_ctrl),
    .in_base   (s1_base),
    .in_offset (s1_offset),
    .in_carry  (s1_carry),
    .valid     (s2_valid),
    .ctrl      (s2_ctrl),
    .base      (s2_base),
    .moved     (s2_moved),
    .carry     (s2_carry)
  );

  alsag_form u_form (
    .clk               (clk),
    .rst               (rst),
    .en                (adv),
    .in_valid          (s2_valid),
    .in_ctrl           (s2_ctrl),
    .in_base           (s2_base),
    .in_moved          (s2_moved),
    .in_carry          (s2_carry),
    .valid             (out_valid),
    .access_kind       (access_kind),
    .access_address    (access_address),
    .new_base          (new_base),
    .base_write_enable (base_write_enable),
    .shifter_carry_out (shifter_carry_out),
    .user_mode_access  (user_mode_access)
  );

  a_we_kind : assert property (@(posedge clk) disable iff (rst)
    out_valid && base_write_enable |->
      access_kind == KIND_PRE || access_kind == KIND_POST)
    else $error("writeback without pre or post indexing");

  a_user_post : assert property (@(posedge clk) disable iff (rst)
    out_valid && user_mode_access |-> access_kind == KIND_POST)
    else $error("user-mode access that is not post-indexed");

  a_none_quiet : assert property (@(posedge clk) disable iff (rst)
    out_valid && access_kind == KIND_NONE |->
      !base_write_enable && access_address == 32'd0)
    else $error("no-access result with address or writeback");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_stall && !$past(out_stall) |=>
      s1_valid)
    else $error("accepted word lost in first stage");

endmodule
